[hw/rtl/lnasm_pkg.sv]
// ----------------------------------------------------------------------------
// lnasm_pkg
// Shared types and constants for the line assembler with echo.
// ----------------------------------------------------------------------------
package lnasm_pkg;

  localparam int FILL_W     = 6;
  localparam int ERR_LEN    = 26;
  localparam int ERR_IDX_W  = 5;
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = 2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_ECHO,
    CMD_ERROR
  } cmd_op_t;

  // count carries the store address for a write and the line length for an echo
  typedef struct packed {
    cmd_op_t           op;
    logic [7:0]        data;
    logic [FILL_W-1:0] count;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ECHO,
    BK_CR,
    BK_LF,
    BK_ERR
  } back_state_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       is_error;
    logic       last;
  } beat_t;

  function automatic logic [7:0] err_char(input logic [ERR_IDX_W-1:0] idx);
    logic [7:0] ch;
    case (idx)
      5'd0:    ch = "E";
      5'd1:    ch = "R";
      5'd2:    ch = "R";
      5'd3:    ch = "O";
      5'd4:    ch = "R";
      5'd5:    ch = ":";
      5'd6:    ch = " ";
      5'd7:    ch = "l";
      5'd8:    ch = "i";
      5'd9:    ch = "n";
      5'd10:   ch = "e";
      5'd11:   ch = "a";
      5'd12:   ch = " ";
      5'd13:   ch = "m";
      5'd14:   ch = "u";
      5'd15:   ch = "y";
      5'd16:   ch = " ";
      5'd17:   ch = "e";
      5'd18:   ch = "x";
      5'd19:   ch = "t";
      5'd20:   ch = "e";
      5'd21:   ch = "n";
      5'd22:   ch = "s";
      5'd23:   ch = "a";
      5'd24:   ch = CH_CR;
      5'd25:   ch = CH_LF;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

[hw/rtl/line_assembler_with_echo.sv]
// ----------------------------------------------------------------------------
// line_assembler_with_echo
// Collects received bytes into lines, echoes completed non-comment lines with
// CR LF, and reports an overflow with a fixed error message.
// ----------------------------------------------------------------------------
// Channel   Handshake           Payload
// in        in_push / in_full   in_rx_byte[7:0]
// out       out_pop / out_empty out_tx_byte[7:0], out_is_error, out_last
//
// A byte is taken whenever the command queue (4 entries) has room. The back
// part picks up each command when idle; an echo then streams one beat per cycle
// while the output queue has room, the store read in the one stage before the
// 2-entry output queue. Stores behind an echo wait until the echo is issued.
// Synchronous active-low reset clears control; the line store needs no clear.
// ----------------------------------------------------------------------------
module line_assembler_with_echo
  import lnasm_pkg::*;
#(
  parameter int LINE_CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_rx_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_tx_byte,
  output logic       out_is_error,
  output logic       out_last
);

  logic q_full, q_empty, q_push, q_pop;
  cmd_t q_cmd, q_head;

  lnasm_front #(.LINE_CAPACITY(LINE_CAPACITY)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  lnasm_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  lnasm_back #(.LINE_CAPACITY(LINE_CAPACITY)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_tx_byte  (out_tx_byte),
    .out_is_error (out_is_error),
    .out_last     (out_last)
  );

endmodule

[hw/rtl/lnasm_front.sv]
// ----------------------------------------------------------------------------
// lnasm_front
// Classifies received bytes and turns them into store/echo/error commands.
// ----------------------------------------------------------------------------
module lnasm_front
  import lnasm_pkg::*;
#(
  parameter int LINE_CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_rx_byte,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam logic [FILL_W-1:0] FULL_AT = FILL_W'(LINE_CAPACITY - 1);

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              open_r, open_nxt;
  logic [7:0]        first_r, second_r;
  logic              accept;
  logic              is_term;
  logic              is_comment;
  logic [FILL_W-1:0] fill_eff;

  assign in_full  = q_full;
  assign accept   = in_push && !q_full;
  assign is_term  = (in_rx_byte == CH_CR) || (in_rx_byte == CH_LF);
  assign fill_eff = open_r ? fill_r : '0;

  assign is_comment = ((fill_r >= FILL_W'(1)) && (first_r == CH_HASH)) ||
                      ((fill_r >= FILL_W'(2)) && (first_r == CH_SLASH) &&
                       (second_r == CH_SLASH));

  always_comb begin
    fill_nxt     = fill_r;
    open_nxt     = open_r;
    q_push       = 1'b0;
    q_cmd.op     = CMD_WRITE;
    q_cmd.data   = in_rx_byte;
    q_cmd.count  = fill_eff;
    if (accept && (in_rx_byte != CH_NUL)) begin
      if (is_term) begin
        if (open_r) begin
          q_push      = !is_comment;
          q_cmd.op    = CMD_ECHO;
          q_cmd.count = fill_r;
          open_nxt    = 1'b0;
          fill_nxt    = '0;
        end
      end else if (fill_eff >= FULL_AT) begin
        q_push   = 1'b1;
        q_cmd.op = CMD_ERROR;
        open_nxt = 1'b0;
        fill_nxt = '0;
      end else begin
        q_push   = 1'b1;
        open_nxt = 1'b1;
        fill_nxt = fill_eff + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      open_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      open_r <= open_nxt;
    end
  end

  // first two bytes of the line feed the comment check
  always_ff @(posedge clk) begin
    if (accept && q_push && (q_cmd.op == CMD_WRITE)) begin
      if (fill_eff == FILL_W'(0)) first_r  <= in_rx_byte;
      if (fill_eff == FILL_W'(1)) second_r <= in_rx_byte;
    end
  end

  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !open_r |-> (fill_r == '0))
    else $error("closed line holds bytes");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_AT)
    else $error("fill count past capacity");

endmodule

[hw/rtl/lnasm_cmdq.sv]
// ----------------------------------------------------------------------------
// lnasm_cmdq
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module lnasm_cmdq
  import lnasm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t               q_mem [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMDQ_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = q_mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + (CMDQ_AW+1)'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - (CMDQ_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + CMDQ_AW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + CMDQ_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_mem[wr_ptr_r] <= push_cmd;
  end

endmodule

[hw/rtl/lnasm_back.sv]
// ----------------------------------------------------------------------------
// lnasm_back
// Executes commands: writes the line store, streams echo and error beats.
// ----------------------------------------------------------------------------
module lnasm_back
  import lnasm_pkg::*;
#(
  parameter int LINE_CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  cmd_t       q_head,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_tx_byte,
  output logic       out_is_error,
  output logic       out_last
);

  localparam int AW = $clog2(LINE_CAPACITY);

  back_state_t       state_r, state_nxt;
  logic [FILL_W-1:0] idx_r, len_r;
  logic [7:0]        line_mem [LINE_CAPACITY];
  logic [7:0]        rdata_r;

  // beat in flight while the store read completes
  logic              p1_valid_r;
  logic              p1_mem_r;
  beat_t             p1_beat_r;

  beat_t             ofifo_r [2];
  logic              owr_r, ord_r;
  logic [1:0]        ocnt_r, ocnt_nxt;
  logic              pop_fire;
  logic [2:0]        occ;
  logic              room;

  logic              issue;
  logic              iss_mem;
  beat_t             iss_beat;
  beat_t             p1_out;

  assign pop_fire = out_pop && (ocnt_r != 2'd0);
  assign occ      = {1'b0, ocnt_r} + {2'b0, p1_valid_r};
  assign room     = (occ - {2'b0, pop_fire}) < 3'd2;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          case (q_head.op)
            CMD_ECHO:  state_nxt = (q_head.count == '0) ? BK_CR : BK_ECHO;
            CMD_ERROR: state_nxt = BK_ERR;
            default:   state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_ECHO: if (room && (idx_r == len_r - FILL_W'(1))) state_nxt = BK_CR;
      BK_CR:   if (room) state_nxt = BK_LF;
      BK_LF:   if (room) state_nxt = BK_IDLE;
      BK_ERR:  if (room && (idx_r == FILL_W'(ERR_LEN - 1))) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop             = 1'b0;
    issue             = 1'b0;
    iss_mem           = 1'b0;
    iss_beat.tx_byte  = CH_NUL;
    iss_beat.is_error = 1'b0;
    iss_beat.last     = 1'b0;
    case (state_r)
      BK_IDLE: q_pop = !q_empty;
      BK_ECHO: begin
        issue   = room;
        iss_mem = 1'b1;
      end
      BK_CR: begin
        issue            = room;
        iss_beat.tx_byte = CH_CR;
      end
      BK_LF: begin
        issue            = room;
        iss_beat.tx_byte = CH_LF;
        iss_beat.last    = 1'b1;
      end
      BK_ERR: begin
        issue             = room;
        iss_beat.tx_byte  = err_char(idx_r[ERR_IDX_W-1:0]);
        iss_beat.is_error = 1'b1;
        iss_beat.last     = (idx_r == FILL_W'(ERR_LEN - 1));
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      idx_r <= '0;
      len_r <= q_head.count;
    end else if (issue) begin
      idx_r <= idx_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_head.op == CMD_WRITE)) line_mem[q_head.count[AW-1:0]] <= q_head.data;
    if (issue && iss_mem) rdata_r <= line_mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_mem_r  <= iss_mem;
      p1_beat_r <= iss_beat;
    end
  end

  always_comb begin
    p1_out         = p1_beat_r;
    p1_out.tx_byte = p1_mem_r ? rdata_r : p1_beat_r.tx_byte;
  end

  // two-entry output queue
  always_comb begin
    ocnt_nxt = ocnt_r;
    if (p1_valid_r && !pop_fire) ocnt_nxt = ocnt_r + 2'd1;
    if (!p1_valid_r && pop_fire) ocnt_nxt = ocnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= '0;
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
    end else begin
      ocnt_r <= ocnt_nxt;
      if (p1_valid_r) owr_r <= !owr_r;
      if (pop_fire)   ord_r <= !ord_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_valid_r) ofifo_r[owr_r] <= p1_out;
  end

  assign out_empty    = (ocnt_r == 2'd0);
  assign out_tx_byte  = ofifo_r[ord_r].tx_byte;
  assign out_is_error = ofifo_r[ord_r].is_error;
  assign out_last     = ofifo_r[ord_r].last;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= 3'd2)
    else $error("output queue overrun");

  a_echo_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_ECHO) |-> (idx_r < len_r))
    else $error("echo index past line length");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (issue && iss_beat.last) |=> (state_r == BK_IDLE))
    else $error("run did not end after last beat");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for line_assembler_with_echo. A byte stream of directed
// and random lines (echoed, comment, stray terminators, overflow) is pushed
// in bursts while the output side pops on a changing stall pattern; every
// popped beat is checked against a line-assembly prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import lnasm_pkg::*;

  localparam int CAP = 32;

  typedef enum logic [1:0] {
    POP_FREE,
    POP_HALF,
    POP_SPARSE,
    POP_BURSTY
  } pop_mode_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_push    = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_pop    = 1'b0;
  logic       in_full;
  logic       out_empty;
  logic [7:0] out_tx_byte;
  logic       out_is_error;
  logic       out_last;

  line_assembler_with_echo #(
    .LINE_CAPACITY(CAP)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_rx_byte  (in_rx_byte),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_tx_byte (out_tx_byte),
    .out_is_error(out_is_error),
    .out_last    (out_last)
  );

  always #6 clk = ~clk;

  logic [7:0] rx_q[$];      // bytes still to be sent
  beat_t      tx_q[$];      // predicted beats, oldest first
  int         rx_count  = 0;
  int         fail_cnt  = 0;

  // predicted block state
  logic [7:0] line_buf[CAP];
  int         line_len  = 0;
  bit         line_busy = 1'b0;

  string      overflow_text = "ERROR: linea muy extensa";

  task automatic queue_beat(input logic [7:0] ch, input logic err, input logic fin);
    beat_t b;
    b.tx_byte  = ch;
    b.is_error = err;
    b.last     = fin;
    tx_q.push_back(b);
  endtask

  task automatic assemble_byte(input logic [7:0] ch);
    bit comment;
    if (ch == CH_NUL) return;
    if (ch == CH_CR || ch == CH_LF) begin
      if (line_busy) begin
        comment = (line_len >= 1 && line_buf[0] == CH_HASH) ||
                  (line_len >= 2 && line_buf[0] == CH_SLASH && line_buf[1] == CH_SLASH);
        if (!comment) begin
          for (int i = 0; i < line_len; i++) queue_beat(line_buf[i], 1'b0, 1'b0);
          queue_beat(CH_CR, 1'b0, 1'b0);
          queue_beat(CH_LF, 1'b0, 1'b1);
        end
        line_busy = 1'b0;
        line_len  = 0;
      end
      return;
    end
    if (!line_busy) begin
      line_busy = 1'b1;
      line_len  = 0;
    end
    if (line_len >= CAP - 1) begin
      // store full: error text replaces the line, byte is lost
      for (int i = 0; i < overflow_text.len(); i++)
        queue_beat(overflow_text[i], 1'b1, 1'b0);
      queue_beat(CH_CR, 1'b1, 1'b0);
      queue_beat(CH_LF, 1'b1, 1'b1);
      line_busy = 1'b0;
      line_len  = 0;
      return;
    end
    line_buf[line_len] = ch;
    line_len++;
  endtask

  // ---- stimulus helpers ----
  task automatic send_byte(input logic [7:0] ch);
    rx_q.push_back(ch);
    if (ch != CH_NUL) rx_count++;
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] ch;
    do ch = 8'($urandom_range(1, 255)); while (ch == CH_CR || ch == CH_LF);
    return ch;
  endfunction

  task automatic send_text(input int n);
    for (int i = 0; i < n; i++) send_byte(text_byte());
  endtask

  task automatic send_term();
    send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  // ---- sender: bursts with gaps ----
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_push    <= 1'b0;
      in_rx_byte <= CH_NUL;
    end else if (gap_left > 0) begin
      gap_left--;
      in_push <= 1'b0;
    end else if (rx_q.size() > 0) begin
      in_push    <= 1'b1;
      in_rx_byte <= rx_q[0];
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
        gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      end
    end else begin
      in_push <= 1'b0;
    end
  end

  // ---- receiver: stall pattern that changes mode now and then ----
  pop_mode_t pop_mode  = POP_FREE;
  int        mode_left = 0;
  int        hold_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        pop_mode  = pop_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      case (pop_mode)
        POP_FREE:   out_pop <= 1'b1;
        POP_HALF:   out_pop <= 1'($urandom_range(0, 1));
        POP_SPARSE: out_pop <= ($urandom_range(0, 3) == 0);
        default: begin
          if (hold_left > 0) begin
            hold_left--;
            out_pop <= 1'b0;
          end else begin
            out_pop   <= 1'b1;
            hold_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
          end
        end
      endcase
    end
  end

  // ---- monitor: input beats feed the prediction, output beats are checked ----
  always @(posedge clk) begin
    beat_t want;
    beat_t got;
    if (rst_n) begin
      if (in_push && in_full === 1'b0) begin
        assemble_byte(in_rx_byte);
        void'(rx_q.pop_front());
      end
      if (out_pop && out_empty === 1'b0) begin
        got.tx_byte  = out_tx_byte;
        got.is_error = out_is_error;
        got.last     = out_last;
        if (tx_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("%0t: unexpected beat: byte %h err %b last %b",
                     $time, got.tx_byte, got.is_error, got.last);
        end else begin
          want = tx_q.pop_front();
          if (got.tx_byte !== want.tx_byte || got.is_error !== want.is_error ||
              got.last !== want.last) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("%0t: mismatch: expected byte %h err %b last %b, got byte %h err %b last %b",
                       $time, want.tx_byte, want.is_error, want.last,
                       got.tx_byte, got.is_error, got.last);
          end
        end
      end
    end
  end

  // ---- stimulus and end of run ----
  initial begin
    int kind;

    // directed: ignored bytes, stray terminators, field extremes
    send_byte(CH_NUL);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte("A"); send_byte(8'hFF); send_byte(8'h80); send_byte(8'h01); send_byte(8'h7F);
    send_byte(CH_CR);
    send_byte("k"); send_byte(CH_NUL); send_byte("m"); send_byte(CH_LF);
    // comment lines
    send_byte(CH_HASH); send_byte("x"); send_byte(CH_LF);
    send_byte(CH_HASH); send_byte(CH_CR);
    send_byte(CH_SLASH); send_byte(CH_SLASH); send_byte("z"); send_byte(CH_CR);
    // lone slash and slash followed by something else are echoed
    send_byte(CH_SLASH); send_byte(CH_LF);
    send_byte(CH_SLASH); send_byte("q"); send_byte(CH_CR);
    // longest line that fits, then an overflow and recovery
    send_text(CAP - 1); send_byte(CH_LF);
    send_text(CAP); send_byte(CH_LF);
    send_byte("b"); send_byte(CH_CR);

    // random: mostly well-formed lines, some noise, until about 100 bytes in all
    while (rx_count < 100) begin
      kind = $urandom_range(0, 29);
      case (kind)
        0: send_term();
        1: send_byte(CH_NUL);
        2: begin
          send_text(CAP + $urandom_range(0, 3));
          if ($urandom_range(0, 1)) send_term();
        end
        3: begin
          send_text($urandom_range(20, CAP - 1));
          send_term();
        end
        4, 5: begin
          if (kind == 4) send_byte(CH_HASH);
          else begin
            send_byte(CH_SLASH);
            send_byte(CH_SLASH);
          end
          send_text($urandom_range(0, 4));
          send_term();
        end
        6: begin
          // raw noise, terminators and zeros anywhere
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        end
        7: begin
          send_byte(CH_SLASH);
          send_text($urandom_range(0, 3));
          send_term();
        end
        default: begin
          send_text($urandom_range(0, 8));
          send_term();
        end
      endcase
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (rx_q.size() != 0) @(posedge clk);
    while (tx_q.size() != 0) @(posedge clk);
    // look for stray beats after the last predicted one
    repeat (60) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
